// ===== sv/psp_pkg.sv =====
// Shared constants and types for the point-to-segment projection block.
// Depends on nothing; every other file of the block imports it.
package psp_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of the reported position and of the quotient built by the cell row.
    localparam int POS_BITS   = 32;
    localparam int QUOT_BITS  = POS_BITS + 1;

    typedef struct packed {
        logic on_seg;
        logic neg;
        logic degen;
        logic ovf;
    } t_flags;

endpackage

// ===== sv/psp_in_if.sv =====
// Request channel of the projection block: one point and one segment.
// Depends on psp_pkg for the default coordinate width.
interface psp_in_if #(
    parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, point_x, point_y, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

// ===== sv/psp_out_if.sv =====
// Result channel of the projection block: position, projection and flags.
// Depends on psp_pkg for the default coordinate width and position width.
interface psp_out_if #(
    parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [psp_pkg::POS_BITS-1:0]  position;
    logic                                 inside_res;
    logic signed [COORD_BITS-1:0]         proj_x;
    logic signed [COORD_BITS-1:0]         proj_y;
    logic                                 degenerate;
    logic                                 saturated;

    modport source (
        output valid, position, inside_res, proj_x, proj_y, degenerate, saturated,
        input  ready
    );
    modport sink (
        input  valid, position, inside_res, proj_x, proj_y, degenerate, saturated,
        output ready
    );
endinterface

// ===== sv/psp_front.sv =====
// Front end: differences, dot products, numerator and denominator, and the
// divider's starting remainder. Four pipeline stages. Depends on psp_pkg.
module psp_front #(
    parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = psp_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_BITS-1:0]  i_px,
    input  logic signed [COORD_BITS-1:0]  i_py,
    input  logic signed [COORD_BITS-1:0]  i_sx,
    input  logic signed [COORD_BITS-1:0]  i_sy,
    input  logic signed [COORD_BITS-1:0]  i_ex,
    input  logic signed [COORD_BITS-1:0]  i_ey,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2*COORD_BITS+1:0]       o_rem,
    output logic [2*COORD_BITS+1:0]       o_den,
    output logic [2*COORD_BITS+1:0]       o_mag,
    output psp_pkg::t_flags               o_flags,
    output logic signed [COORD_BITS-1:0]  o_sx,
    output logic signed [COORD_BITS-1:0]  o_sy,
    output logic signed [COORD_BITS:0]    o_dx,
    output logic signed [COORD_BITS:0]    o_dy
);
    import psp_pkg::*;

    localparam int DW        = 2 * COORD_BITS + 2;
    localparam int NW        = 2 * COORD_BITS + 3;
    localparam int PRE_SHIFT = QUOT_BITS - FRAC_BITS;

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic w_ld_a, w_ld_b, w_ld_c, w_ld_d;

    logic signed [COORD_BITS:0]   r_a_vx, r_a_vy, r_a_dx, r_a_dy;
    logic signed [COORD_BITS-1:0] r_a_sx, r_a_sy;

    logic signed [DW-1:0]         r_b_pn0, r_b_pn1, r_b_pd0, r_b_pd1;
    logic signed [COORD_BITS:0]   r_b_dx, r_b_dy;
    logic signed [COORD_BITS-1:0] r_b_sx, r_b_sy;

    logic signed [NW-1:0]         r_c_num;
    logic [DW-1:0]                r_c_den;
    logic signed [COORD_BITS:0]   r_c_dx, r_c_dy;
    logic signed [COORD_BITS-1:0] r_c_sx, r_c_sy;

    logic [DW-1:0]                r_d_rem, r_d_den, r_d_mag;
    t_flags                       r_d_flags;
    logic signed [COORD_BITS:0]   r_d_dx, r_d_dy;
    logic signed [COORD_BITS-1:0] r_d_sx, r_d_sy;

    logic          w_neg;
    logic [NW-1:0] w_abs;
    logic [DW-1:0] w_mag, w_init;
    t_flags        w_flags;

    assign w_ld_d  = !r_d_valid || i_ready;
    assign w_ld_c  = !r_c_valid || w_ld_d;
    assign w_ld_b  = !r_b_valid || w_ld_c;
    assign w_ld_a  = !r_a_valid || w_ld_b;
    assign o_ready = w_ld_a;
    assign o_valid = r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_ld_a) r_a_valid <= i_valid;
            if (w_ld_b) r_b_valid <= r_a_valid;
            if (w_ld_c) r_c_valid <= r_b_valid;
            if (w_ld_d) r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a) begin
            r_a_vx <= {i_px[COORD_BITS-1], i_px} - {i_sx[COORD_BITS-1], i_sx};
            r_a_vy <= {i_py[COORD_BITS-1], i_py} - {i_sy[COORD_BITS-1], i_sy};
            r_a_dx <= {i_ex[COORD_BITS-1], i_ex} - {i_sx[COORD_BITS-1], i_sx};
            r_a_dy <= {i_ey[COORD_BITS-1], i_ey} - {i_sy[COORD_BITS-1], i_sy};
            r_a_sx <= i_sx;
            r_a_sy <= i_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_b) begin
            r_b_pn0 <= r_a_vx * r_a_dx;
            r_b_pn1 <= r_a_vy * r_a_dy;
            r_b_pd0 <= r_a_dx * r_a_dx;
            r_b_pd1 <= r_a_dy * r_a_dy;
            r_b_dx  <= r_a_dx;
            r_b_dy  <= r_a_dy;
            r_b_sx  <= r_a_sx;
            r_b_sy  <= r_a_sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_c) begin
            r_c_num <= {r_b_pn0[DW-1], r_b_pn0} + {r_b_pn1[DW-1], r_b_pn1};
            r_c_den <= r_b_pd0 + r_b_pd1;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_sx  <= r_b_sx;
            r_c_sy  <= r_b_sy;
        end
    end

    always_comb begin
        w_neg          = r_c_num[NW-1];
        w_abs          = w_neg ? (~r_c_num + 1'b1) : r_c_num;
        w_mag          = w_abs[DW-1:0];
        w_init         = w_mag >> PRE_SHIFT;
        w_flags.on_seg = !w_neg && (r_c_num[DW-1:0] <= r_c_den) && (r_c_den != '0);
        w_flags.neg    = w_neg;
        w_flags.degen  = (r_c_den == '0);
        w_flags.ovf    = (w_init >= r_c_den);
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_d) begin
            r_d_rem   <= w_init;
            r_d_den   <= r_c_den;
            r_d_mag   <= w_mag;
            r_d_flags <= w_flags;
            r_d_dx    <= r_c_dx;
            r_d_dy    <= r_c_dy;
            r_d_sx    <= r_c_sx;
            r_d_sy    <= r_c_sy;
        end
    end

    assign o_rem   = r_d_rem;
    assign o_den   = r_d_den;
    assign o_mag   = r_d_mag;
    assign o_flags = r_d_flags;
    assign o_sx    = r_d_sx;
    assign o_sy    = r_d_sy;
    assign o_dx    = r_d_dx;
    assign o_dy    = r_d_dy;

endmodule

// ===== sv/psp_div_cell.sv =====
// One cell of the divider row: decides one quotient bit by a trial subtract
// and hands remainder and request data to the next cell. Depends on psp_pkg.
module psp_div_cell #(
    parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = psp_pkg::FRAC_BITS_DEF,
    parameter int IDX        = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [2*COORD_BITS+1:0]          i_rem,
    input  logic [2*COORD_BITS+1:0]          i_den,
    input  logic [2*COORD_BITS+1:0]          i_mag,
    input  logic [psp_pkg::QUOT_BITS-1:0]    i_quot,
    input  psp_pkg::t_flags                  i_flags,
    input  logic signed [COORD_BITS-1:0]     i_sx,
    input  logic signed [COORD_BITS-1:0]     i_sy,
    input  logic signed [COORD_BITS:0]       i_dx,
    input  logic signed [COORD_BITS:0]       i_dy,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2*COORD_BITS+1:0]          o_rem,
    output logic [2*COORD_BITS+1:0]          o_den,
    output logic [2*COORD_BITS+1:0]          o_mag,
    output logic [psp_pkg::QUOT_BITS-1:0]    o_quot,
    output psp_pkg::t_flags                  o_flags,
    output logic signed [COORD_BITS-1:0]     o_sx,
    output logic signed [COORD_BITS-1:0]     o_sy,
    output logic signed [COORD_BITS:0]       o_dx,
    output logic signed [COORD_BITS:0]       o_dy
);
    import psp_pkg::*;

    localparam int DW      = 2 * COORD_BITS + 2;
    localparam int BIT_POS = QUOT_BITS - 1 - IDX;
    localparam int MAG_IDX = BIT_POS - FRAC_BITS;

    logic                         r_valid;
    logic                         w_ld;
    logic                         w_bit;
    logic [DW:0]                  w_shift, w_diff;
    logic                         w_ge;
    logic [QUOT_BITS-1:0]         w_quot;
    logic [DW-1:0]                r_rem, r_den, r_mag;
    logic [QUOT_BITS-1:0]         r_quot;
    t_flags                       r_flags;
    logic signed [COORD_BITS-1:0] r_sx, r_sy;
    logic signed [COORD_BITS:0]   r_dx, r_dy;

    // The dividend is the magnitude shifted up by the fraction width.
    generate
        if (MAG_IDX >= 0 && MAG_IDX < DW) begin : g_mag_bit
            assign w_bit = i_mag[MAG_IDX];
        end else begin : g_zero_bit
            assign w_bit = 1'b0;
        end
    endgenerate

    always_comb begin
        w_shift         = {i_rem, w_bit};
        w_diff          = w_shift - {1'b0, i_den};
        w_ge            = (w_shift >= {1'b0, i_den});
        w_quot          = i_quot;
        w_quot[BIT_POS] = w_ge;
    end

    assign w_ld    = !r_valid || i_ready;
    assign o_ready = w_ld;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_rem   <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_den   <= i_den;
            r_mag   <= i_mag;
            r_quot  <= w_quot;
            r_flags <= i_flags;
            r_sx    <= i_sx;
            r_sy    <= i_sy;
            r_dx    <= i_dx;
            r_dy    <= i_dy;
        end
    end

    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_mag   = r_mag;
    assign o_quot  = r_quot;
    assign o_flags = r_flags;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;

endmodule

// ===== sv/psp_back.sv =====
// Back end: saturation and sign of the position, then the projected point
// with round half up. Three stages, the last is the output register.
// Depends on psp_pkg.
module psp_back #(
    parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = psp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [psp_pkg::QUOT_BITS-1:0]       i_quot,
    input  psp_pkg::t_flags                     i_flags,
    input  logic signed [COORD_BITS-1:0]        i_sx,
    input  logic signed [COORD_BITS-1:0]        i_sy,
    input  logic signed [COORD_BITS:0]          i_dx,
    input  logic signed [COORD_BITS:0]          i_dy,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [psp_pkg::POS_BITS-1:0] o_position,
    output logic                                o_inside,
    output logic signed [COORD_BITS-1:0]        o_proj_x,
    output logic signed [COORD_BITS-1:0]        o_proj_y,
    output logic                                o_degen,
    output logic                                o_sat
);
    import psp_pkg::*;

    localparam int PW = FRAC_BITS + COORD_BITS + 3;
    localparam logic [POS_BITS-1:0] NEG_LIMIT = {1'b1, {(POS_BITS-1){1'b0}}};
    localparam logic [POS_BITS-1:0] POS_LIMIT = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic r_e_valid, r_f_valid, r_g_valid;
    logic w_ld_e, w_ld_f, w_ld_g;

    logic [POS_BITS-1:0] w_limit, w_mag, w_pos;
    logic                w_sat;

    logic [POS_BITS-1:0]          r_e_pos;
    logic [FRAC_BITS:0]           r_e_tq;
    logic                         r_e_inside, r_e_degen, r_e_sat;
    logic signed [COORD_BITS-1:0] r_e_sx, r_e_sy;
    logic signed [COORD_BITS:0]   r_e_dx, r_e_dy;

    logic [POS_BITS-1:0]          r_f_pos;
    logic signed [PW-1:0]         r_f_prod_x, r_f_prod_y;
    logic                         r_f_inside, r_f_degen, r_f_sat;
    logic signed [COORD_BITS-1:0] r_f_sx, r_f_sy;

    logic signed [PW-1:0]         w_sum_x, w_sum_y, w_q_x, w_q_y;
    logic [COORD_BITS-1:0]        w_proj_x, w_proj_y;

    logic [POS_BITS-1:0]          r_g_pos;
    logic [COORD_BITS-1:0]        r_g_proj_x, r_g_proj_y;
    logic                         r_g_inside, r_g_degen, r_g_sat;

    assign w_ld_g  = !r_g_valid || i_ready;
    assign w_ld_f  = !r_f_valid || w_ld_g;
    assign w_ld_e  = !r_e_valid || w_ld_f;
    assign o_ready = w_ld_e;
    assign o_valid = r_g_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else begin
            if (w_ld_e) r_e_valid <= i_valid;
            if (w_ld_f) r_f_valid <= r_e_valid;
            if (w_ld_g) r_g_valid <= r_f_valid;
        end
    end

    always_comb begin
        w_limit = i_flags.neg ? NEG_LIMIT : POS_LIMIT;
        w_sat   = !i_flags.degen && (i_flags.ovf || (i_quot > {1'b0, w_limit}));
        w_mag   = w_sat ? w_limit : i_quot[POS_BITS-1:0];
        if (i_flags.degen) begin
            w_pos = '0;
        end else if (i_flags.neg) begin
            w_pos = POS_BITS'(~w_mag + 1'b1);
        end else begin
            w_pos = w_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_e) begin
            r_e_pos    <= w_pos;
            r_e_tq     <= w_mag[FRAC_BITS:0];
            r_e_inside <= i_flags.on_seg;
            r_e_degen  <= i_flags.degen;
            r_e_sat    <= w_sat;
            r_e_sx     <= i_sx;
            r_e_sy     <= i_sy;
            r_e_dx     <= i_dx;
            r_e_dy     <= i_dy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_f) begin
            r_f_pos    <= r_e_pos;
            r_f_prod_x <= $signed({1'b0, r_e_tq}) * r_e_dx;
            r_f_prod_y <= $signed({1'b0, r_e_tq}) * r_e_dy;
            r_f_inside <= r_e_inside;
            r_f_degen  <= r_e_degen;
            r_f_sat    <= r_e_sat;
            r_f_sx     <= r_e_sx;
            r_f_sy     <= r_e_sy;
        end
    end

    always_comb begin
        w_sum_x  = r_f_prod_x + RND;
        w_sum_y  = r_f_prod_y + RND;
        w_q_x    = w_sum_x >>> FRAC_BITS;
        w_q_y    = w_sum_y >>> FRAC_BITS;
        w_proj_x = r_f_sx + w_q_x[COORD_BITS-1:0];
        w_proj_y = r_f_sy + w_q_y[COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_g) begin
            r_g_pos    <= r_f_pos;
            r_g_proj_x <= r_f_inside ? w_proj_x : '0;
            r_g_proj_y <= r_f_inside ? w_proj_y : '0;
            r_g_inside <= r_f_inside;
            r_g_degen  <= r_f_degen;
            r_g_sat    <= r_f_sat;
        end
    end

    assign o_position = r_g_pos;
    assign o_inside   = r_g_inside;
    assign o_proj_x   = r_g_proj_x;
    assign o_proj_y   = r_g_proj_y;
    assign o_degen    = r_g_degen;
    assign o_sat      = r_g_sat;

endmodule

// ===== sv/point_segment_projection.sv =====
// Projects a point onto a segment and reports the parametric position t as signed
// fixed point (truncated toward zero, saturated with a flag), whether t lies in
// [0,1], the rounded projected point when it does, and a flag for a zero-length
// segment. A new request is taken every cycle while the output side does not stall;
// each result passes through four front stages for the dot products, a row of 33
// divider cells that each settle one quotient bit, and three back stages for
// saturation, projection and the output register.
// Stalls propagate stage by stage, so empty stages keep filling while a result waits.
// Depends on psp_pkg, psp_in_if, psp_out_if, psp_front, psp_div_cell and psp_back.
module point_segment_projection #(
    parameter int COORD_BITS = psp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = psp_pkg::FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    psp_in_if.sink    i_in,
    psp_out_if.source o_out
);
    import psp_pkg::*;

    localparam int DW = 2 * COORD_BITS + 2;

    logic                         w_valid [QUOT_BITS+1];
    logic                         w_ready [QUOT_BITS+1];
    logic [DW-1:0]                w_rem   [QUOT_BITS+1];
    logic [DW-1:0]                w_den   [QUOT_BITS+1];
    logic [DW-1:0]                w_mag   [QUOT_BITS+1];
    logic [QUOT_BITS-1:0]         w_quot  [QUOT_BITS+1];
    t_flags                       w_flags [QUOT_BITS+1];
    logic signed [COORD_BITS-1:0] w_sx    [QUOT_BITS+1];
    logic signed [COORD_BITS-1:0] w_sy    [QUOT_BITS+1];
    logic signed [COORD_BITS:0]   w_dx    [QUOT_BITS+1];
    logic signed [COORD_BITS:0]   w_dy    [QUOT_BITS+1];

    assign w_quot[0] = '0;

    psp_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_px    (i_in.point_x),
        .i_py    (i_in.point_y),
        .i_sx    (i_in.start_x),
        .i_sy    (i_in.start_y),
        .i_ex    (i_in.end_x),
        .i_ey    (i_in.end_y),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_rem   (w_rem[0]),
        .o_den   (w_den[0]),
        .o_mag   (w_mag[0]),
        .o_flags (w_flags[0]),
        .o_sx    (w_sx[0]),
        .o_sy    (w_sy[0]),
        .o_dx    (w_dx[0]),
        .o_dy    (w_dy[0])
    );

    generate
        for (genvar g = 0; g < QUOT_BITS; g++) begin : g_cell
            psp_div_cell #(
                .COORD_BITS (COORD_BITS),
                .FRAC_BITS  (FRAC_BITS),
                .IDX        (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_rem   (w_rem[g]),
                .i_den   (w_den[g]),
                .i_mag   (w_mag[g]),
                .i_quot  (w_quot[g]),
                .i_flags (w_flags[g]),
                .i_sx    (w_sx[g]),
                .i_sy    (w_sy[g]),
                .i_dx    (w_dx[g]),
                .i_dy    (w_dy[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_rem   (w_rem[g+1]),
                .o_den   (w_den[g+1]),
                .o_mag   (w_mag[g+1]),
                .o_quot  (w_quot[g+1]),
                .o_flags (w_flags[g+1]),
                .o_sx    (w_sx[g+1]),
                .o_sy    (w_sy[g+1]),
                .o_dx    (w_dx[g+1]),
                .o_dy    (w_dy[g+1])
            );
        end
    endgenerate

    psp_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[QUOT_BITS]),
        .o_ready    (w_ready[QUOT_BITS]),
        .i_quot     (w_quot[QUOT_BITS]),
        .i_flags    (w_flags[QUOT_BITS]),
        .i_sx       (w_sx[QUOT_BITS]),
        .i_sy       (w_sy[QUOT_BITS]),
        .i_dx       (w_dx[QUOT_BITS]),
        .i_dy       (w_dy[QUOT_BITS]),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_position (o_out.position),
        .o_inside   (o_out.inside_res),
        .o_proj_x   (o_out.proj_x),
        .o_proj_y   (o_out.proj_y),
        .o_degen    (o_out.degenerate),
        .o_sat      (o_out.saturated)
    );

endmodule

// ===== sim/tb_point_segment_projection.sv =====
// Self-checking testbench for point_segment_projection: directed and random point/segment
// requests, each result compared against an in-bench projection model, with random idling.
// Depends on psp_pkg, psp_in_if, psp_out_if and the point_segment_projection RTL.
`timescale 1ns / 1ps

module tb_point_segment_projection;

    localparam int CW = psp_pkg::COORD_BITS_DEF;
    localparam int FW = psp_pkg::FRAC_BITS_DEF;
    localparam int MAX_IDLE = 12;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } t_query;

    typedef struct packed {
        logic signed [psp_pkg::POS_BITS-1:0] position;
        logic                                on_segment;
        logic signed [CW-1:0]                proj_x;
        logic signed [CW-1:0]                proj_y;
        logic                                degenerate;
        logic                                saturated;
    } t_projection;

    logic i_clk = 1'b0;
    logic i_rst_n;

    psp_in_if  #(.COORD_BITS(CW)) req_if ();
    psp_out_if #(.COORD_BITS(CW)) res_if ();

    point_segment_projection #(
        .COORD_BITS(CW),
        .FRAC_BITS (FW)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_if),
        .o_out  (res_if)
    );

    t_projection pending_results[$];
    t_projection want;
    bit sender_idle;
    bit sink_idle;
    int sink_hold;
    int mismatch_count;
    int results_checked;
    int queries_sent;
    int degenerate_count;
    int inside_count;
    int clamped_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic signed [CW-1:0] project_axis(input logic signed [CW-1:0] s,
                                                          input longint t_fix,
                                                          input longint d);
        longint along;
        longint sum;
        along = (t_fix * d + (longint'(1) <<< (FW - 1))) >>> FW;
        sum = longint'(s) + along;
        return sum[CW-1:0];
    endfunction

    function automatic t_projection predict_projection(input t_query q);
        t_projection r;
        longint dx, dy, num, den, mag, t_fix, lim, pos;
        r = '0;
        dx = longint'($signed(q.ex)) - longint'($signed(q.sx));
        dy = longint'($signed(q.ey)) - longint'($signed(q.sy));
        num = (longint'($signed(q.px)) - longint'($signed(q.sx))) * dx
            + (longint'($signed(q.py)) - longint'($signed(q.sy))) * dy;
        den = dx * dx + dy * dy;
        if (den == 0) begin
            r.degenerate = 1'b1;
        end else begin
            mag = (num < 0) ? -num : num;
            lim = (num < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
            t_fix = (mag <<< FW) / den;
            if (t_fix > lim) begin
                t_fix = lim;
                r.saturated = 1'b1;
            end
            pos = (num < 0) ? -t_fix : t_fix;
            r.position = pos[psp_pkg::POS_BITS-1:0];
            if (num >= 0 && num <= den) begin
                r.on_segment = 1'b1;
                r.proj_x = project_axis(q.sx, t_fix, dx);
                r.proj_y = project_axis(q.sy, t_fix, dy);
            end
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] any_coord();
        logic [31:0] r;
        r = $urandom;
        return r[CW-1:0];
    endfunction

    function automatic longint offset_within(input int n);
        return longint'($urandom_range(0, 2 * n)) - n;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    function automatic t_query make_query(input int px, input int py, input int sx,
                                          input int sy, input int ex, input int ey);
        t_query q;
        q.px = CW'(px);
        q.py = CW'(py);
        q.sx = CW'(sx);
        q.sy = CW'(sy);
        q.ex = CW'(ex);
        q.ey = CW'(ey);
        return q;
    endfunction

    // Four in ten requests put the point near the segment so that the inside path and the
    // projection rounding get exercised; the rest are degenerate, short or unrelated.
    function automatic t_query random_query();
        t_query q;
        int kind;
        int spread;
        longint dx, dy, k;
        q.px = any_coord();
        q.py = any_coord();
        q.sx = any_coord();
        q.sy = any_coord();
        q.ex = any_coord();
        q.ey = any_coord();
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                q.ex = q.sx;
                q.ey = q.sy;
            end
            1, 2: begin
            end
            3, 4, 5, 6: begin
                case ($urandom_range(0, 2))
                    0: spread = 16;
                    1: spread = 1024;
                    default: spread = 65535;
                endcase
                q.ex = clamp_coord($signed(q.sx) + offset_within(spread));
                q.ey = clamp_coord($signed(q.sy) + offset_within(spread));
                dx = longint'($signed(q.ex)) - longint'($signed(q.sx));
                dy = longint'($signed(q.ey)) - longint'($signed(q.sy));
                k = longint'($urandom_range(0, 320)) - 32;
                q.px = clamp_coord($signed(q.sx) + ((dx * k) >>> 8) + offset_within(8));
                q.py = clamp_coord($signed(q.sy) + ((dy * k) >>> 8) + offset_within(8));
            end
            7, 8: begin
                q.ex = clamp_coord($signed(q.sx) + offset_within(2));
                q.ey = clamp_coord($signed(q.sy) + offset_within(2));
            end
            default: begin
                q.px = clamp_coord(offset_within(8));
                q.py = clamp_coord(offset_within(8));
                q.sx = clamp_coord(offset_within(8));
                q.sy = clamp_coord(offset_within(8));
                q.ex = clamp_coord(offset_within(8));
                q.ey = clamp_coord(offset_within(8));
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string field, input longint exp_val,
                                   input longint got_val);
        mismatch_count++;
        $display("MISMATCH at result %0d, %s: expected %0d, got %0d",
                 results_checked, field, exp_val, got_val);
    endtask

    task automatic send_query(input t_query q);
        int gap;
        t_projection p;
        gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.point_x <= q.px;
        req_if.point_y <= q.py;
        req_if.start_x <= q.sx;
        req_if.start_y <= q.sy;
        req_if.end_x   <= q.ex;
        req_if.end_y   <= q.ey;
        do @(posedge i_clk); while (!req_if.ready);
        p = predict_projection(q);
        pending_results.push_back(p);
        queries_sent++;
        degenerate_count += int'(p.degenerate);
        inside_count += int'(p.on_segment);
        clamped_count += int'(p.saturated);
    endtask

    task automatic test_degenerate();
        send_query(make_query(0, 0, 0, 0, 0, 0));
        send_query(make_query(32767, -32768, 5, 5, 5, 5));
        send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768));
        send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767));
    endtask

    task automatic test_endpoints_and_rounding();
        send_query(make_query(-100, 50, -100, 50, 300, -20));
        send_query(make_query(300, -20, -100, 50, 300, -20));
        send_query(make_query(1, 0, 0, 0, 2, 0));
        send_query(make_query(1, 0, 0, 0, 1, 1));
        send_query(make_query(-1, 0, 0, 0, -1, -1));
        send_query(make_query(1, 5, 0, 0, 3, 0));
        send_query(make_query(11, 3, 0, 0, 10, 0));
        send_query(make_query(-1, 3, 0, 0, 10, 0));
    endtask

    task automatic test_saturation();
        send_query(make_query(32767, 0, 0, 0, 1, 0));
        send_query(make_query(32767, 0, -1, 0, 0, 0));
        send_query(make_query(-32768, 0, 0, 0, 1, 0));
        send_query(make_query(-32768, 0, 32766, 0, 32767, 0));
        send_query(make_query(32767, 32767, -32768, -32768, -32767, -32768));
    endtask

    task automatic test_extremes();
        send_query(make_query(32767, -32768, -32768, -32768, 32767, 32767));
        send_query(make_query(32767, 32767, -32768, -32768, 32767, 32767));
        send_query(make_query(-32768, 32767, 32767, 32767, -32768, -32768));
        send_query(make_query(0, 32767, -32768, 0, 32767, 0));
        send_query(make_query(-32768, -32768, 32767, -32768, -32768, 32767));
    endtask

    task automatic test_random_stream(input int n);
        sender_idle = 1'b1;
        sink_idle = 1'b1;
        repeat (n) send_query(random_query());
    endtask

    // The sink stops taking results for a long stretch while requests keep coming,
    // so the pipeline fills and the request side has to stall.
    task automatic test_back_pressure(input int n);
        sender_idle = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 250;
        repeat (n) send_query(random_query());
    endtask

    task automatic test_steady_stream(input int n);
        sender_idle = 1'b0;
        sink_idle = 1'b0;
        repeat (n) send_query(random_query());
    endtask

    initial begin : result_sink
        int wait_cycles;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            wait_cycles = (sink_idle ? $urandom_range(0, MAX_IDLE) : 0) + sink_hold;
            sink_hold = 0;
            if (wait_cycles > 0) begin
                res_if.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding", 0, 1);
            end else begin
                want = pending_results.pop_front();
                if (res_if.position !== want.position)
                    report_mismatch("position", want.position, res_if.position);
                if (res_if.inside_res !== want.on_segment)
                    report_mismatch("inside_res", want.on_segment, res_if.inside_res);
                if (res_if.proj_x !== want.proj_x)
                    report_mismatch("proj_x", want.proj_x, res_if.proj_x);
                if (res_if.proj_y !== want.proj_y)
                    report_mismatch("proj_y", want.proj_y, res_if.proj_y);
                if (res_if.degenerate !== want.degenerate)
                    report_mismatch("degenerate", want.degenerate, res_if.degenerate);
                if (res_if.saturated !== want.saturated)
                    report_mismatch("saturated", want.saturated, res_if.saturated);
            end
            results_checked++;
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", pending_results.size());
        $display("tb_point_segment_projection NOT OK");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.point_x <= '0;
        req_if.point_y <= '0;
        req_if.start_x <= '0;
        req_if.start_y <= '0;
        req_if.end_x   <= '0;
        req_if.end_y   <= '0;
        sender_idle = 1'b1;
        sink_idle = 1'b1;
        sink_hold = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_degenerate();
        test_endpoints_and_rounding();
        test_saturation();
        test_extremes();
        test_random_stream(250);
        test_back_pressure(100);
        test_steady_stream(150);

        req_if.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results for %0d requests, %0d mismatches.",
                 results_checked, queries_sent, mismatch_count);
        $display("Seen: %0d zero-length segments, %0d on the segment, %0d clamped positions.",
                 degenerate_count, inside_count, clamped_count);
        if (mismatch_count == 0) begin
            $display("tb_point_segment_projection OK");
        end else begin
            $display("tb_point_segment_projection NOT OK");
        end
        $finish;
    end

endmodule

// ===== point_segment_projection.f =====
sv/psp_pkg.sv
sv/psp_in_if.sv
sv/psp_out_if.sv
sv/psp_front.sv
sv/psp_div_cell.sv
sv/psp_back.sv
sv/point_segment_projection.sv
sim/tb_point_segment_projection.sv
